// File: sv/olar_pkg.sv
package olar_pkg;

   localparam int DEF_CAPACITY = 32;
   localparam int VALUE_W      = 32;
   localparam int POS_W        = 7;
   localparam int SLOT_W       = 6;
   localparam int ACT_W        = 2;
   localparam int STAT_W       = 2;
   localparam int REQ_DATA_W   = 40;
   localparam int RSP_DATA_W   = 40;

   typedef enum logic [ACT_W-1:0] {
      ACT_APPEND  = 2'd0,
      ACT_RMV_VAL = 2'd1,
      ACT_RMV_AT  = 2'd2,
      ACT_DUMP    = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_MISS  = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic       latch;
      logic       idx_clr;
      logic       idx_pos;
      logic       idx_inc;
      logic       rd_en;
      logic       rd_next;
      logic       wr_app;
      logic       wr_shift;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       out_load;
      logic       out_dump;
      status_type out_status;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic pos_ok;
      logic idx_below;
      logic more;
      logic last;
      logic hit;
      logic out_free;
   } stat_type;

endpackage

// File: sv/olar_ram.sv
module olar_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/olar_datapath.sv
module olar_datapath
   import olar_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tready,
   input  cmd_type               cmd,
   output stat_type              stat,
   output logic                  rsp_valid,
   output status_type            rsp_status,
   output logic [VALUE_W-1:0]    rsp_element,
   output logic [SLOT_W-1:0]     rsp_slot,
   output logic                  rsp_last
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);

   logic [VALUE_W-1:0] val_ff, val_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   idx_ff, idx_in, idx_nxt;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0] rsp_element_ff, rsp_element_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [VALUE_W-1:0] rd_data;

   assign idx_nxt = idx_ff + CNT_W'(1);

   always_comb begin
      val_in = cmd.latch ? req_tdata[VALUE_W-1:0] : val_ff;
      pos_in = cmd.latch ? req_tdata[VALUE_W +: POS_W] : pos_ff;

      priority if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_pos) begin
         idx_in = CNT_W'(pos_ff);
      end else if (cmd.idx_inc) begin
         idx_in = idx_nxt;
      end else begin
         idx_in = idx_ff;
      end

      priority if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      stat.full      = (count_ff == CNT_W'(CAPACITY));
      stat.empty     = (count_ff == '0);
      stat.pos_ok    = (pos_ff < POS_W'(count_ff));
      stat.idx_below = (idx_ff < count_ff);
      stat.more      = (idx_nxt < count_ff);
      stat.last      = (idx_nxt == count_ff);
      stat.hit       = (rd_data == val_ff);
      stat.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign wr_en   = cmd.wr_app || cmd.wr_shift;
   assign wr_addr = cmd.wr_app ? count_ff[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];
   assign wr_data = cmd.wr_app ? val_ff : rd_data;
   assign rd_addr = cmd.rd_next ? idx_nxt[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];

   olar_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_olar_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_last_in    = rsp_last_ff;
      if (cmd.out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = cmd.out_status;
         rsp_element_in = cmd.out_dump ? rd_data : '0;
         rsp_slot_in    = cmd.out_dump ? SLOT_W'(idx_ff) : '0;
         rsp_last_in    = cmd.out_dump ? stat.last : 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff         <= val_in;
      pos_ff         <= pos_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_slot    = rsp_slot_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

// File: sv/olar_ctrl.sv
module olar_ctrl
   import olar_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  action_type req_action,
   output logic       req_ready,
   input  stat_type   stat,
   output cmd_type    cmd
);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_APPEND   = 10'b00_0000_0010,
      S_SRCH_RD  = 10'b00_0000_0100,
      S_SRCH_CMP = 10'b00_0000_1000,
      S_AT_CHK   = 10'b00_0001_0000,
      S_SHIFT_RD = 10'b00_0010_0000,
      S_SHIFT_WR = 10'b00_0100_0000,
      S_DUMP_RD  = 10'b00_1000_0000,
      S_DUMP_OUT = 10'b01_0000_0000,
      S_REPLY    = 10'b10_0000_0000
   } state_type;

   state_type  state_ff, state_in;
   status_type st_ff, st_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd            = '0;
      cmd.out_status = st_ff;
      state_in       = state_ff;
      st_in          = st_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch   = 1'b1;
               cmd.idx_clr = 1'b1;
               unique case (req_action)
                  ACT_APPEND:  state_in = S_APPEND;
                  ACT_RMV_VAL: state_in = S_SRCH_RD;
                  ACT_RMV_AT:  state_in = S_AT_CHK;
                  ACT_DUMP:    state_in = S_DUMP_RD;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_APPEND: begin
            if (stat.full) begin
               st_in = ST_FULL;
            end else begin
               cmd.wr_app  = 1'b1;
               cmd.cnt_inc = 1'b1;
               st_in       = ST_DONE;
            end
            state_in = S_REPLY;
         end
         S_SRCH_RD: begin
            if (stat.idx_below) begin
               cmd.rd_en = 1'b1;
               state_in  = S_SRCH_CMP;
            end else begin
               st_in    = ST_MISS;
               state_in = S_REPLY;
            end
         end
         S_SRCH_CMP: begin
            if (stat.hit) begin
               state_in = S_SHIFT_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SRCH_RD;
            end
         end
         S_AT_CHK: begin
            if (stat.pos_ok) begin
               cmd.idx_pos = 1'b1;
               state_in    = S_SHIFT_RD;
            end else begin
               st_in    = ST_MISS;
               state_in = S_REPLY;
            end
         end
         S_SHIFT_RD: begin
            if (stat.more) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = S_SHIFT_WR;
            end else begin
               cmd.cnt_dec = 1'b1;
               st_in       = ST_DONE;
               state_in    = S_REPLY;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_DUMP_RD: begin
            if (stat.empty) begin
               st_in    = ST_EMPTY;
               state_in = S_REPLY;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_DUMP_OUT;
            end
         end
         S_DUMP_OUT: begin
            cmd.out_status = ST_DONE;
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_dump = 1'b1;
               if (stat.last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_DUMP_RD;
               end
            end
         end
         S_REPLY: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff    <= ST_DONE;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
      end
   end

endmodule

// File: sv/ordered_list_append_remove.sv
// Append and both removes answer with a single status beat, as does a dump of an empty
// list; otherwise a dump sends one beat per element, slot 0 first. Remove-by-value reads
// each entry from slot 0 until a hit, remove-at checks the position against the count;
// on success, either shifts the later entries down one slot. One request at a time; the
// next is taken the cycle after the last response beat is loaded.
// Reset clears the count and the output valid; store contents are left as they are.
module ordered_list_append_remove
   import olar_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // value[31:0], position[38:32], zero[39]
   input  logic [ACT_W-1:0]      req_tuser,  // action[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // element[31:0], slot[37:32], zero[39:38]
   output logic [STAT_W-1:0]     rsp_tuser,  // status[1:0]
   output logic                  rsp_tlast
);

   cmd_type            cmd;
   stat_type           stat;
   logic               req_ready;
   status_type         rsp_status;
   logic [VALUE_W-1:0] rsp_element;
   logic [SLOT_W-1:0]  rsp_slot;

   olar_ctrl u_olar_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_action (action_type'(req_tuser)),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   olar_datapath #(
      .CAPACITY (CAPACITY)
   ) u_olar_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .rsp_tready  (rsp_tready),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_tvalid),
      .rsp_status  (rsp_status),
      .rsp_element (rsp_element),
      .rsp_slot    (rsp_slot),
      .rsp_last    (rsp_tlast)
   );

   assign req_tready = req_ready;
   assign rsp_tuser  = rsp_status;
   assign rsp_tdata  = {(RSP_DATA_W - SLOT_W - VALUE_W)'(0), rsp_slot, rsp_element};

endmodule

// File: sv/olar_checker.sv
module olar_checker
   import olar_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [ACT_W-1:0]      req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STAT_W-1:0]     rsp_tuser,
   input logic                  rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response beat changed while stalled");

   a_status_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_DONE |-> rsp_tlast && rsp_tdata == '0)
      else $error("status-only beat not a single zero beat");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in flight");

   a_dump_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready && rsp_tuser == ST_DONE)
      else $error("request taken in the middle of a dump");

   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:VALUE_W+SLOT_W] == '0)
      else $error("response pad bits not zero");

endmodule

bind ordered_list_append_remove olar_checker u_olar_checker (.*);

// File: sim/ordered_list_checker.sv
module ordered_list_checker
   import olar_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // value[31:0], position[38:32], zero[39]
   input  logic [ACT_W-1:0]      req_tuser,  // action[1:0]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,  // element[31:0], slot[37:32], zero[39:38]
   input  logic [STAT_W-1:0]     rsp_tuser,  // status[1:0]
   input  logic                  rsp_tlast,
   output int                    fail_count,
   output int                    pending,
   output int                    req_beats,
   output int                    rsp_beats,
   output int                    peak_fill,
   output int                    full_drops,
   output int                    dumps
);

   typedef struct packed {
      status_type           status;
      logic [VALUE_W-1:0]   element;
      logic [SLOT_W-1:0]    slot;
      logic                 last;
   } list_beat_type;

   logic [VALUE_W-1:0] shadow_list [CAPACITY];
   int                 shadow_count = 0;
   list_beat_type      expected_beats [$];

   int n_fail = 0;
   int n_pending = 0;
   int n_req = 0;
   int n_rsp = 0;
   int n_peak = 0;
   int n_full = 0;
   int n_dump = 0;

   assign fail_count = n_fail;
   assign pending    = n_pending;
   assign req_beats  = n_req;
   assign rsp_beats  = n_rsp;
   assign peak_fill  = n_peak;
   assign full_drops = n_full;
   assign dumps      = n_dump;

   task automatic push_beat(input status_type status, input logic [VALUE_W-1:0] element,
                            input logic [SLOT_W-1:0] slot, input logic last);
      list_beat_type beat;
      beat.status  = status;
      beat.element = element;
      beat.slot    = slot;
      beat.last    = last;
      expected_beats.push_back(beat);
   endtask

   task automatic remove_entry(input int at);
      for (int i = at; i + 1 < shadow_count; i++) begin
         shadow_list[i] = shadow_list[i + 1];
      end
      shadow_count--;
   endtask

   task automatic apply_request(input action_type act, input logic [VALUE_W-1:0] val,
                                input logic [POS_W-1:0] pos);
      int hit;
      hit = -1;
      case (act)
         ACT_APPEND: begin
            if (shadow_count >= CAPACITY) begin
               n_full++;
               push_beat(ST_FULL, '0, '0, 1'b1);
            end else begin
               shadow_list[shadow_count] = val;
               shadow_count++;
               push_beat(ST_DONE, '0, '0, 1'b1);
            end
         end
         ACT_RMV_VAL: begin
            for (int i = 0; i < shadow_count; i++) begin
               if (hit < 0 && shadow_list[i] == val) begin
                  hit = i;
               end
            end
            if (hit >= 0) begin
               remove_entry(hit);
               push_beat(ST_DONE, '0, '0, 1'b1);
            end else begin
               push_beat(ST_MISS, '0, '0, 1'b1);
            end
         end
         ACT_RMV_AT: begin
            if (int'(pos) < shadow_count) begin
               remove_entry(int'(pos));
               push_beat(ST_DONE, '0, '0, 1'b1);
            end else begin
               push_beat(ST_MISS, '0, '0, 1'b1);
            end
         end
         default: begin
            n_dump++;
            if (shadow_count == 0) begin
               push_beat(ST_EMPTY, '0, '0, 1'b1);
            end else begin
               for (int i = 0; i < shadow_count; i++) begin
                  push_beat(ST_DONE, shadow_list[i], SLOT_W'(i), i + 1 == shadow_count);
               end
            end
         end
      endcase
      if (shadow_count > n_peak) begin
         n_peak = shadow_count;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         n_fail++;
      end
   endtask

   always @(posedge clock) begin
      list_beat_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            n_rsp++;
            if (expected_beats.size() == 0) begin
               $error("response beat with nothing expected: status %0d element %0h slot %0d",
                      rsp_tuser, rsp_tdata[VALUE_W-1:0], rsp_tdata[VALUE_W+SLOT_W-1:VALUE_W]);
               n_fail++;
            end else begin
               want = expected_beats.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_tuser));
               check_field("element", want.element, rsp_tdata[VALUE_W-1:0]);
               check_field("slot", 32'(want.slot), 32'(rsp_tdata[VALUE_W+SLOT_W-1:VALUE_W]));
               check_field("last", 32'(want.last), 32'(rsp_tlast));
               check_field("pad", 32'd0, 32'(rsp_tdata[RSP_DATA_W-1:VALUE_W+SLOT_W]));
            end
         end
         if (req_tvalid && req_tready) begin
            n_req++;
            apply_request(action_type'(req_tuser), req_tdata[VALUE_W-1:0],
                          req_tdata[VALUE_W+POS_W-1:VALUE_W]);
         end
         n_pending = expected_beats.size();
      end
   end

endmodule

// File: sim/tb_ordered_list_append_remove.sv
module tb_ordered_list_append_remove;
   import olar_pkg::*;

   localparam int CAPACITY     = DEF_CAPACITY;
   localparam int RANDOM_ITEMS = 450;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

   typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_MASK} rx_mode_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // value[31:0], position[38:32], zero[39]
   logic [ACT_W-1:0]      req_tuser = '0;  // action[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // element[31:0], slot[37:32], zero[39:38]
   logic [STAT_W-1:0]     rsp_tuser;       // status[1:0]
   logic                  rsp_tlast;

   int fail_count, pending, req_beats, rsp_beats, peak_fill, full_drops, dumps;

   int                 cycles = 0;
   int                 burst_left = 0;
   logic [VALUE_W-1:0] append_log [$];

   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 0;
   logic [7:0]  rx_mask = 8'hff;
   logic [2:0]  rx_phase = '0;

   ordered_list_append_remove #(.CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   ordered_list_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending),
      .req_beats  (req_beats),
      .rsp_beats  (rsp_beats),
      .peak_fill  (peak_fill),
      .full_drops (full_drops),
      .dumps      (dumps)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_left <= $urandom_range(16, 160);
         rx_mask <= 8'($urandom_range(1, 255));
      end else begin
         rx_left <= rx_left - 1;
      end
      rx_phase <= rx_phase + 3'd1;
      case (rx_mode)
         RX_OPEN: rsp_tready <= 1'b1;
         RX_COIN: rsp_tready <= 1'($urandom_range(0, 1));
         RX_SLOW: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= rx_mask[rx_phase];
      endcase
   end

   task automatic send_item(input action_type act, input logic [VALUE_W-1:0] val,
                            input logic [POS_W-1:0] pos);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {1'b0, pos, val};
      if (act == ACT_APPEND) begin
         append_log.push_back(val);
         if (append_log.size() > 48) begin
            void'(append_log.pop_front());
         end
      end
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         return 32'($urandom_range(0, 7)) - 32'd4;
      end else if (r < 40) begin
         return ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      end
      return $urandom();
   endfunction

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      action_type         act;
      logic [VALUE_W-1:0] val;
      logic [POS_W-1:0]   pos;
      int                 r;
      int                 phase_left;
      bit                 grow;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_item(ACT_DUMP, 32'd0, 7'd0);
      send_item(ACT_RMV_VAL, 32'd0, 7'd0);
      send_item(ACT_RMV_AT, 32'd0, 7'd0);
      send_item(ACT_RMV_AT, 32'hffff_ffff, 7'd127);
      send_item(ACT_APPEND, 32'h8000_0000, 7'd0);
      send_item(ACT_APPEND, 32'h7fff_ffff, 7'd127);
      send_item(ACT_APPEND, 32'h0000_0000, 7'd0);
      send_item(ACT_APPEND, 32'hffff_ffff, 7'd0);
      send_item(ACT_APPEND, 32'd5, 7'd0);
      send_item(ACT_APPEND, 32'd5, 7'd0);
      send_item(ACT_DUMP, 32'd0, 7'd0);
      send_item(ACT_RMV_VAL, 32'd5, 7'd0);
      send_item(ACT_RMV_VAL, 32'd1234, 7'd0);
      send_item(ACT_RMV_AT, 32'd0, 7'd5);
      send_item(ACT_RMV_AT, 32'd0, 7'd4);
      send_item(ACT_RMV_AT, 32'd0, 7'd0);
      send_item(ACT_RMV_VAL, 32'hffff_ffff, 7'd0);
      send_item(ACT_DUMP, 32'd0, 7'd0);
      send_item(ACT_RMV_AT, 32'd0, 7'd63);
      send_item(ACT_RMV_VAL, 32'h8000_0000, 7'd0);
      send_item(ACT_DUMP, 32'd0, 7'd0);

      grow = 1'b0;
      phase_left = 0;
      repeat (RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            grow = !grow;
            phase_left = $urandom_range(20, 60);
         end
         phase_left--;
         r = $urandom_range(0, 99);
         if (grow) begin
            act = (r < 65) ? ACT_APPEND : (r < 76) ? ACT_RMV_VAL
                : (r < 88) ? ACT_RMV_AT : ACT_DUMP;
         end else begin
            act = (r < 15) ? ACT_APPEND : (r < 50) ? ACT_RMV_VAL
                : (r < 87) ? ACT_RMV_AT : ACT_DUMP;
         end
         if (act == ACT_RMV_VAL && append_log.size() > 0 && $urandom_range(0, 99) < 60) begin
            val = append_log[$urandom_range(0, append_log.size() - 1)];
         end else begin
            val = pick_value();
         end
         pos = ($urandom_range(0, 99) < 70) ? 7'($urandom_range(0, 35))
                                           : 7'($urandom_range(0, 127));
         send_item(act, val, pos);
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d requests driven, %0d response beats checked, %0d dumps",
               req_beats, rsp_beats, dumps);
      $display("run: list filled up to %0d of %0d, %0d appends dropped on a full list",
               peak_fill, CAPACITY, full_drops);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/olar_pkg.sv
sv/olar_ram.sv
sv/olar_datapath.sv
sv/olar_ctrl.sv
sv/ordered_list_append_remove.sv
sv/olar_checker.sv
sim/ordered_list_checker.sv
sim/tb_ordered_list_append_remove.sv
